@@ sv/polyline_corridor_simplifier_defines.svh @@
// Assertion macros shared by the simplifier.
`ifndef POLYLINE_CORRIDOR_SIMPLIFIER_DEFINES_SVH
`define POLYLINE_CORRIDOR_SIMPLIFIER_DEFINES_SVH
`define PCS_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("pcs check failed");
`define PCS_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("pcs check failed");
`endif

@@ sv/pcs_pkg.sv @@
package pcs_pkg;
	localparam int MaxSpan = 64;
	localparam int SpanIdxW = $clog2(MaxSpan);
	localparam int SpanCntW = $clog2(MaxSpan + 1);
	localparam logic [9:0] TolReset = 10'd2;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic               final_point;
	} point_t;

	typedef struct packed {
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic               final_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [16:0] qx;
		logic signed [16:0] qy;
		logic signed [16:0] px;
		logic signed [16:0] py;
		logic [19:0]        d2;
	} chk_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic fail;
	} chk_stat_t;
endpackage

@@ sv/pcs_span_mem.sv @@
module pcs_span_mem (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [pcs_pkg::SpanIdxW-1:0] wr_addr,
	input  logic [31:0]                wr_data,
	input  logic [pcs_pkg::SpanIdxW-1:0] rd_addr,
	output logic [31:0]                rd_data
);
	import pcs_pkg::*;
	logic [31:0] mem [MaxSpan];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

@@ sv/pcs_check.sv @@
module pcs_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pcs_pkg::chk_req_t req,
	output pcs_pkg::chk_stat_t stat
);
	import pcs_pkg::*;

	// Stages: products, squares and compares, verdict.
	logic               v_s1, v_s2;
	logic signed [34:0] cr_s1, dot_s1, q2_s1, s_s1, r2_s1;
	logic [19:0]        d2_s1, d2_s2;
	logic [33:0]        ue_s2;
	logic               big_s2;
	logic [53:0]        lim_s2;
	logic signed [34:0] dot_s2, s_s2, q2_s2, r2_s2;
	logic [67:0]        ue2;
	logic signed [17:0] rx, ry;
	logic               pass;

	assign rx = 18'(req.qx) - 18'(req.px);
	assign ry = 18'(req.qy) - 18'(req.py);

	always_ff @(posedge clk) begin
		cr_s1  <= 35'(req.qx * req.py) - 35'(req.qy * req.px);
		dot_s1 <= 35'(req.px * req.qx) + 35'(req.py * req.qy);
		q2_s1  <= 35'(req.qx * req.qx) + 35'(req.qy * req.qy);
		s_s1   <= 35'(req.px * req.px) + 35'(req.py * req.py);
		r2_s1  <= 35'(rx * rx) + 35'(ry * ry);
		d2_s1  <= req.d2;
		ue_s2  <= cr_s1[34] ? 34'(-cr_s1) : 34'(cr_s1);
		big_s2 <= (cr_s1[34] ? 35'(-cr_s1) : cr_s1) > 35'sh0_FFFF_FFFF;
		lim_s2 <= 54'(s_s1) * 54'(d2_s1);
		dot_s2 <= dot_s1;
		s_s2   <= s_s1;
		q2_s2  <= q2_s1;
		r2_s2  <= r2_s1;
		d2_s2  <= d2_s1;
	end

	assign ue2 = 68'(ue_s2[31:0]) * 68'(ue_s2[31:0]);

	always_comb begin
		if (big_s2 || ue2 > 68'(lim_s2)) begin
			pass = 1'b0;
		end else if (dot_s2 > 0 && dot_s2 <= s_s2) begin
			pass = 1'b1;
		end else if (dot_s2 <= 0) begin
			pass = q2_s2 <= 35'(d2_s2);
		end else begin
			pass = r2_s2 <= 35'(d2_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	assign stat.busy = v_s1 | v_s2;
	assign stat.done = v_s2;
	assign stat.fail = v_s2 & ~pass;
endmodule

@@ sv/polyline_corridor_simplifier.sv @@
// Channel  | Direction | Handshake
// point    | in        | point_valid / point_stall
// vertex   | out       | vertex_valid / vertex_stall
// cfg      | in        | cfg_valid / cfg_ready
// For a point, each buffered point since the anchor is read from the span
// memory and run through the corridor check before the next read; the scan
// stops at the first failure and is skipped once 64 points are buffered.
// Up to three vertices follow a point, one per accepted output cycle.
// The reset clears the control state; the span memory needs no clearing.
`include "polyline_corridor_simplifier_defines.svh"
module polyline_corridor_simplifier (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [9:0]       cfg_data,
	input  logic             point_valid,
	output logic             point_stall,
	input  pcs_pkg::point_t  point,
	output logic             vertex_valid,
	input  logic             vertex_stall,
	output pcs_pkg::vertex_t vertex
);
	import pcs_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_READ = 6'b000010,
		ST_WAIT = 6'b000100,
		ST_DEC  = 6'b001000,
		ST_OUT  = 6'b010000,
		ST_COMM = 6'b100000
	} state_t;

	state_t             state_q;
	logic [19:0]        d2_q;
	logic signed [15:0] ax_q, ay_q, cx_q, cy_q, hx_q, hy_q, lx_q, ly_q;
	logic               fin_q, fail_q;
	logic [1:0]         phase_q;
	logic [SpanCntW-1:0] cnt_q, idx_q;
	vertex_t            obuf_q [3];
	logic [1:0]         onum_q, optr_q;
	logic               rd_v_q;
	logic [31:0]        rd_data;
	chk_req_t           req;
	chk_stat_t          stat;
	logic               wr_en;
	logic [SpanIdxW-1:0] wr_addr;

	assign cfg_ready = state_q == ST_IDLE;
	assign point_stall = state_q != ST_IDLE;
	assign vertex_valid = state_q == ST_OUT;
	assign vertex = obuf_q[optr_q];

	assign req.qx = 17'(signed'(rd_data[15:0])) - 17'(ax_q);
	assign req.qy = 17'(signed'(rd_data[31:16])) - 17'(ay_q);
	assign req.px = 17'(cx_q) - 17'(ax_q);
	assign req.py = 17'(cy_q) - 17'(ay_q);
	assign req.d2 = d2_q;

	assign wr_en = state_q == ST_COMM;

	pcs_span_mem u_mem (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr),
		.wr_data({cy_q, cx_q}), .rd_addr(idx_q[SpanIdxW-1:0]), .rd_data(rd_data)
	);

	pcs_check u_chk (.clk(clk), .arst_n(arst_n), .start(rd_v_q), .req(req), .stat(stat));

	logic force_v;
	assign force_v = fail_q || cnt_q >= SpanCntW'(MaxSpan);
	assign wr_addr = (cnt_q != '0 && force_v) ? '0 : cnt_q[SpanIdxW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			d2_q <= 20'(TolReset) * 20'(TolReset);
			ax_q <= '0; ay_q <= '0; cx_q <= '0; cy_q <= '0;
			hx_q <= '0; hy_q <= '0; lx_q <= '0; ly_q <= '0;
			fin_q <= 1'b0; fail_q <= 1'b0;
			phase_q <= '0; cnt_q <= '0; idx_q <= '0;
			onum_q <= '0; optr_q <= '0; rd_v_q <= 1'b0;
			obuf_q <= '{default: '0};
		end else begin
			rd_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						d2_q <= 20'(cfg_data) * 20'(cfg_data);
					end
					if (point_valid) begin
						cx_q <= point.point_x;
						cy_q <= point.point_y;
						fin_q <= point.final_point;
						fail_q <= 1'b0;
						idx_q <= '0;
						onum_q <= '0;
						optr_q <= '0;
						if (phase_q == 2'd0) begin
							if (point.final_point) begin
								obuf_q[0] <= '{point.point_x, point.point_y, 1'b1};
								onum_q <= 2'd1;
								state_q <= ST_OUT;
							end else begin
								ax_q <= point.point_x; ay_q <= point.point_y;
								hx_q <= point.point_x; hy_q <= point.point_y;
								cnt_q <= '0;
								phase_q <= 2'd1;
							end
						end else if (cnt_q == '0 || cnt_q >= SpanCntW'(MaxSpan)) begin
							state_q <= ST_DEC;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					rd_v_q <= 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (stat.done) begin
						if (stat.fail) begin
							fail_q <= 1'b1;
							state_q <= ST_DEC;
						end else if (idx_q + 1'b1 >= cnt_q) begin
							state_q <= ST_DEC;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_DEC: begin
					logic [1:0] n;
					logic [1:0] ph;
					n = '0;
					ph = phase_q;
					if (cnt_q != '0 && force_v) begin
						if (ph == 2'd1) begin
							obuf_q[n] <= '{hx_q, hy_q, 1'b0};
							n = n + 1'b1;
							ph = 2'd2;
						end
						obuf_q[n] <= '{lx_q, ly_q, 1'b0};
						n = n + 1'b1;
					end
					if (fin_q) begin
						if (ph == 2'd1 && (hx_q != cx_q || hy_q != cy_q)) begin
							obuf_q[n] <= '{hx_q, hy_q, 1'b0};
							n = n + 1'b1;
						end
						obuf_q[n] <= '{cx_q, cy_q, 1'b1};
						n = n + 1'b1;
					end
					phase_q <= ph;
					onum_q <= n;
					state_q <= ST_COMM;
				end
				ST_COMM: begin
					// A forced vertex moves the anchor to the last accepted point.
					if (cnt_q != '0 && force_v) begin
						ax_q <= lx_q; ay_q <= ly_q;
						cnt_q <= SpanCntW'(1);
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
					lx_q <= cx_q; ly_q <= cy_q;
					if (fin_q) begin
						cnt_q <= '0;
						phase_q <= 2'd0;
					end
					state_q <= onum_q != '0 ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (!vertex_stall) begin
						if (optr_q + 1'b1 == onum_q) begin
							state_q <= ST_IDLE;
						end else begin
							optr_q <= optr_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PCS_ASSERT_IMPL(a_out_excl, clk, arst_n, vertex_valid, point_stall)
	`PCS_ASSERT_IMPL(a_chk_idle, clk, arst_n, state_q == ST_IDLE, !stat.busy)
	`PCS_ASSERT_NEXT(a_cnt_max, clk, arst_n, 1'b1, cnt_q <= SpanCntW'(MaxSpan))
endmodule
